FILE: rtl/sector_cache_lru_writeback_core_macros.svh
// ----------------------------------------------------------------------------
// sector cache assertion macros
// property shorthands on clk with rst as the disable condition
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_LRU_WRITEBACK_CORE_MACROS_SVH
`define SECTOR_CACHE_LRU_WRITEBACK_CORE_MACROS_SVH

// same-cycle implication
`define SCL_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sector cache check failed");

// next-cycle implication
`define SCL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sector cache check failed");

`endif

FILE: rtl/scl_pkg.sv
// ----------------------------------------------------------------------------
// scl_pkg
// shared codes and controller/datapath interface types of the sector cache
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  localparam int FLUSH_CAP = 16;
  localparam int CNT_W     = $clog2(FLUSH_CAP);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic flush_emit;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic dirty_any;
    logic dirty_more;
  } dp_status_t;

endpackage

FILE: rtl/scl_ctrl.sv
// ----------------------------------------------------------------------------
// scl_ctrl
// sequencer: accepts words, steps access update and flush writeback walk
// ----------------------------------------------------------------------------
module scl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [1:0]            mode,
  output logic                  in_ready,
  output scl_pkg::ctrl_cmd_t    cmd,
  input  scl_pkg::dp_status_t   status
);

  scl_pkg::state_t             state, state_next;
  logic [scl_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic                        flush_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scl_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign flush_last = !status.dirty_any || !status.dirty_more ||
                      (cnt == scl_pkg::CNT_W'(scl_pkg::FLUSH_CAP - 1));

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      scl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (mode) inside
            scl_pkg::MODE_READ, scl_pkg::MODE_WRITE: begin
              state_next = scl_pkg::ST_UPDATE;
            end
            scl_pkg::MODE_FLUSH: begin
              state_next = scl_pkg::ST_FLUSH;
              cnt_next   = '0;
            end
            default: begin
              state_next = scl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      scl_pkg::ST_UPDATE: begin
        if (status.out_free) begin
          cmd.update = 1'b1;
          state_next = scl_pkg::ST_IDLE;
        end
      end
      scl_pkg::ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush_emit = 1'b1;
          cmd.last       = flush_last;
          cnt_next       = cnt + 1'b1;
          if (flush_last) begin
            state_next = scl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = scl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/scl_dp.sv
// ----------------------------------------------------------------------------
// scl_dp
// tag, status and age registers, tag match, slot choice, output register
// ----------------------------------------------------------------------------
module scl_dp #(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scl_pkg::ctrl_cmd_t    cmd,
  output scl_pkg::dp_status_t   status,
  input  logic [1:0]            mode,
  input  logic [31:0]           sector,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_wdata,
  output logic [31:0]           cfg_rdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [3:0]            slot,
  output logic                  hit,
  output logic                  fetch_valid,
  output logic [31:0]           fetch_sector,
  output logic                  writeback_valid,
  output logic [31:0]           writeback_sector,
  output logic                  last
);

  localparam int IW = $clog2(SLOTS);

  logic [31:0]      tag [SLOTS];
  logic [IW-1:0]    age [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [SLOTS-1:0] dirty;
  logic [31:0]      base;

  logic [31:0]      sector_q;
  logic             write_q;
  logic             hit_q;
  logic [IW-1:0]    hit_idx_q;
  logic             free_q;
  logic [IW-1:0]    free_idx_q;
  logic [IW-1:0]    lru_idx_q;

  logic             hit_n;
  logic [IW-1:0]    hit_idx_n;
  logic             free_n;
  logic [IW-1:0]    free_idx_n;
  logic [IW-1:0]    lru_idx_n;

  logic [IW-1:0]    sel;
  logic             sel_valid;
  logic [IW-1:0]    sel_age;
  logic             evict_wb;
  logic [IW+3:0]    sel_ext;

  logic             fl_any;
  logic [IW-1:0]    fl_idx;
  logic [SLOTS-1:0] fl_mask;
  logic [IW+3:0]    fl_ext;

  logic             out_free;

  assign cfg_rdata = base;
  assign out_free  = !out_valid || out_ready;

  // tag match, free slot and lru victim against the incoming sector
  always_comb begin
    hit_n      = 1'b0;
    hit_idx_n  = '0;
    free_n     = 1'b0;
    free_idx_n = '0;
    lru_idx_n  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (valid[i] && (tag[i] == sector)) begin
        hit_n     = 1'b1;
        hit_idx_n = IW'(i);
      end
      if (!valid[i]) begin
        free_n     = 1'b1;
        free_idx_n = IW'(i);
      end
      if (valid[i] && (age[i] == IW'(SLOTS - 1))) begin
        lru_idx_n = IW'(i);
      end
    end
  end

  // lowest dirty slot for flush
  always_comb begin
    fl_any  = 1'b0;
    fl_idx  = '0;
    fl_mask = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (dirty[i]) begin
        fl_any = 1'b1;
        fl_idx = IW'(i);
      end
    end
    if (fl_any) begin
      fl_mask[fl_idx] = 1'b1;
    end
  end

  assign status.out_free   = out_free;
  assign status.dirty_any  = fl_any;
  assign status.dirty_more = |(dirty & ~fl_mask);

  assign sel       = hit_q ? hit_idx_q : (free_q ? free_idx_q : lru_idx_q);
  assign sel_valid = hit_q || !free_q;
  assign sel_age   = age[sel];
  assign evict_wb  = !hit_q && !free_q && dirty[sel];
  assign sel_ext   = {4'b0000, sel};
  assign fl_ext    = {4'b0000, fl_idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      base      <= '0;
      valid     <= '0;
      dirty     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        base <= cfg_wdata;
      end
      if (cmd.update || cmd.flush_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.update) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (valid[i] && (!sel_valid || (age[i] < sel_age))) begin
            age[i] <= age[i] + 1'b1;
          end
        end
        age[sel]   <= '0;
        tag[sel]   <= sector_q;
        valid[sel] <= 1'b1;
        dirty[sel] <= write_q || (hit_q && dirty[sel]);
      end
      if (cmd.flush_emit) begin
        if (fl_any) begin
          dirty[fl_idx] <= 1'b0;
        end
      end
    end
  end

  // captured access word and lookup results
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sector_q   <= sector;
      write_q    <= (mode == scl_pkg::MODE_WRITE);
      hit_q      <= hit_n;
      hit_idx_q  <= hit_idx_n;
      free_q     <= free_n;
      free_idx_q <= free_idx_n;
      lru_idx_q  <= lru_idx_n;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      slot             <= sel_ext[3:0];
      hit              <= hit_q;
      fetch_valid      <= !hit_q;
      fetch_sector     <= hit_q ? 32'd0 : (sector_q + base);
      writeback_valid  <= evict_wb;
      writeback_sector <= evict_wb ? (tag[sel] + base) : 32'd0;
      last             <= 1'b1;
    end else if (cmd.flush_emit) begin
      slot             <= fl_any ? fl_ext[3:0] : 4'd0;
      hit              <= 1'b0;
      fetch_valid      <= 1'b0;
      fetch_sector     <= 32'd0;
      writeback_valid  <= fl_any;
      writeback_sector <= fl_any ? (tag[fl_idx] + base) : 32'd0;
      last             <= cmd.last;
    end
  end

endmodule

FILE: rtl/sector_cache_lru_writeback_core.sv
// ----------------------------------------------------------------------------
// sector_cache_lru_writeback_core
// tag and lru replacement controller of a fully associative sector cache
// ----------------------------------------------------------------------------
// A read or write access runs the tag compare against all slots in the cycle
// the word is accepted; the update state that follows picks the slot,
// updates tags, dirty bits and slot ages and loads the output register. That
// update waits while the output register still holds an untaken word.
// A flush is accepted and then emits its results from the flush state,
// walking dirty slots lowest first through a priority encoder; an unused mode
// is accepted and gives no result. Recency is kept as a per-slot age, so no
// clearing pass follows reset. disk_base_sector sits at byte address 0.
module sector_cache_lru_writeback_core #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] sector,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  slot,
  output logic        hit,
  output logic        fetch_valid,
  output logic [31:0] fetch_sector,
  output logic        writeback_valid,
  output logic [31:0] writeback_sector,
  output logic        last
);

`include "sector_cache_lru_writeback_core_macros.svh"

  scl_pkg::ctrl_cmd_t  cmd;
  scl_pkg::dp_status_t status;
  logic                cfg_we;
  logic [31:0]         cfg_rdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : cfg_rdata;

  scl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  scl_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .mode             (mode),
    .sector           (sector),
    .cfg_we           (cfg_we),
    .cfg_wdata        (pwdata),
    .cfg_rdata        (cfg_rdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .slot             (slot),
    .hit              (hit),
    .fetch_valid      (fetch_valid),
    .fetch_sector     (fetch_sector),
    .writeback_valid  (writeback_valid),
    .writeback_sector (writeback_sector),
    .last             (last)
  );

  `SCL_ASSERT_NEXT(a_busy_after_access, in_valid && in_ready && (mode == scl_pkg::MODE_READ || mode == scl_pkg::MODE_WRITE), !in_ready)
  `SCL_ASSERT_IMPL(a_hit_no_fetch, out_valid, !(hit && (fetch_valid || writeback_valid)))
  `SCL_ASSERT_IMPL(a_non_last_is_flush, out_valid && !last, writeback_valid && !fetch_valid)

endmodule

FILE: bench/sector_cache_lru_writeback_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sector_cache_lru_writeback_core_tb
// Drives read, write, flush and unused-mode words into the sector cache
// controller. Writes the disk base over APB between phases while the block
// is idle. Checks every result word against an in-bench LRU cache predictor.
// Phases vary sender idling and receiver stalls. One phase holds off the
// receiver for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module sector_cache_lru_writeback_core_tb;

  localparam int SLOTS = 16;
  localparam int POOL_N = 24;
  localparam int HOLD_CYCLES = 300;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_DISK_BASE = 3'd0;
  localparam logic [1:0] SLOT_INVALID = 2'd0;
  localparam logic [1:0] SLOT_CLEAN = 2'd1;
  localparam logic [1:0] SLOT_DIRTY = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sector;
  } access_word_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic        hit;
    logic        fetch_valid;
    logic [31:0] fetch_sector;
    logic        writeback_valid;
    logic [31:0] writeback_sector;
    logic        last;
  } lookup_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = scl_pkg::MODE_READ;
  logic [31:0] sector = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  slot;
  logic        hit;
  logic        fetch_valid;
  logic [31:0] fetch_sector;
  logic        writeback_valid;
  logic [31:0] writeback_sector;
  logic        last;

  access_word_t pending_words[$];
  lookup_word_t expected_lookups[$];

  // predictor state
  logic [31:0] tag_copy [SLOTS];
  logic [1:0]  status_copy [SLOTS];
  logic [3:0]  lru_order [SLOTS];
  logic [4:0]  lru_count = '0;
  logic [31:0] disk_base = '0;

  logic [31:0] sector_pool [POOL_N];
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  bit hold_done;
  int hold_cnt;
  int mismatches = 0;

  sector_cache_lru_writeback_core #(.SLOTS(SLOTS)) DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .sector(sector),
    .out_valid(out_valid), .out_ready(out_ready),
    .slot(slot), .hit(hit), .fetch_valid(fetch_valid), .fetch_sector(fetch_sector),
    .writeback_valid(writeback_valid), .writeback_sector(writeback_sector),
    .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic predict_lookup(input logic [1:0] m, input logic [31:0] sec);
    lookup_word_t r;
    int s;
    int n;
    int ndirty;
    int pos;
    bit found;
    bit got;
    if (m == scl_pkg::MODE_FLUSH) begin
      ndirty = 0;
      for (int i = 0; i < SLOTS; i++)
        if (status_copy[i] == SLOT_DIRTY) ndirty++;
      if (ndirty > scl_pkg::FLUSH_CAP) ndirty = scl_pkg::FLUSH_CAP;
      if (ndirty == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_lookups.push_back(r);
      end else begin
        n = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (status_copy[i] == SLOT_DIRTY && n < ndirty) begin
            r = '0;
            r.slot = i[3:0];
            r.writeback_valid = 1'b1;
            r.writeback_sector = tag_copy[i] + disk_base;
            r.last = (n == ndirty - 1);
            status_copy[i] = SLOT_CLEAN;
            expected_lookups.push_back(r);
            n++;
          end
        end
      end
    end else if (m == scl_pkg::MODE_READ || m == scl_pkg::MODE_WRITE) begin
      r = '0;
      s = 0;
      found = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && status_copy[i] != SLOT_INVALID && tag_copy[i] == sec) begin
          s = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        got = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!got && status_copy[i] == SLOT_INVALID) begin
            s = i;
            got = 1'b1;
          end
        end
        if (!got) begin
          s = (lru_count > 0) ? int'(lru_order[0]) : 0;
          if (status_copy[s] == SLOT_DIRTY) begin
            r.writeback_valid = 1'b1;
            r.writeback_sector = tag_copy[s] + disk_base;
          end
        end
        r.fetch_valid = 1'b1;
        r.fetch_sector = sec + disk_base;
        tag_copy[s] = sec;
        status_copy[s] = SLOT_CLEAN;
      end
      // move slot to most recent end
      pos = -1;
      for (int i = 0; i < SLOTS; i++)
        if (pos < 0 && i < lru_count && lru_order[i] == s[3:0]) pos = i;
      if (pos >= 0) begin
        for (int j = pos; j + 1 < lru_count; j++) lru_order[j] = lru_order[j + 1];
        lru_count = lru_count - 5'd1;
      end
      lru_order[lru_count] = s[3:0];
      lru_count = lru_count + 5'd1;
      if (m == scl_pkg::MODE_WRITE) status_copy[s] = SLOT_DIRTY;
      r.slot = s[3:0];
      r.hit = found;
      r.last = 1'b1;
      expected_lookups.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // driver
  always @(posedge clk) begin : driver
    access_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_lookup(mode, sector);
      if (!in_valid || in_ready) begin
        if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          mode <= w.mode;
          sector <= w.sector;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with a one-shot long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_cnt <= 0;
      hold_done <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    lookup_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_lookups.size() == 0) begin
        $error("result word with no expectation: slot %h", slot);
        mismatches++;
      end else begin
        e = expected_lookups.pop_front();
        check_field("slot", 32'(e.slot), 32'(slot));
        check_field("hit", 32'(e.hit), 32'(hit));
        check_field("fetch_valid", 32'(e.fetch_valid), 32'(fetch_valid));
        check_field("fetch_sector", e.fetch_sector, fetch_sector);
        check_field("writeback_valid", 32'(e.writeback_valid), 32'(writeback_valid));
        check_field("writeback_sector", e.writeback_sector, writeback_sector);
        check_field("last", 32'(e.last), 32'(last));
      end
    end
  end

  task automatic queue_word(input logic [1:0] m, input logic [31:0] sec);
    access_word_t w;
    w.mode = m;
    w.sector = sec;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || expected_lookups.size() != 0)
      @(negedge clk);
    // unused-mode words give no result; let them clear the block
    repeat (8) @(posedge clk);
  endtask

  task automatic start_phase(input logic [31:0] base, input int idle, input int stall);
    wait_drained();
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_DISK_BASE;
    pwdata <= base;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    disk_base = base;
    idle_pct = idle;
    stall_pct = stall;
  endtask

  task automatic fill_random(input int n);
    int r;
    logic [1:0] m;
    logic [31:0] sec;
    for (int i = 0; i < POOL_N; i++) sector_pool[i] = $urandom;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) m = MODE_UNUSED;
      else if (r < 13) m = scl_pkg::MODE_FLUSH;
      else if (r < 55) m = scl_pkg::MODE_READ;
      else m = scl_pkg::MODE_WRITE;
      if ($urandom_range(9) == 0) sec = $urandom;
      else sec = sector_pool[$urandom_range(POOL_N - 1)];
      queue_word(m, sec);
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      tag_copy[i] = '0;
      status_copy[i] = SLOT_INVALID;
      lru_order[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty flush, wrap, unused mode, fill, dirty and clean evictions
    start_phase(32'hFFFF_FFF0, 25, 25);
    queue_word(scl_pkg::MODE_FLUSH, 32'hFFFF_FFFF);
    queue_word(scl_pkg::MODE_WRITE, 32'hFFFF_FFFF);
    queue_word(scl_pkg::MODE_READ, 32'h0000_0000);
    queue_word(MODE_UNUSED, $urandom);
    queue_word(scl_pkg::MODE_READ, 32'h0000_0000);
    queue_word(scl_pkg::MODE_WRITE, 32'h0000_0000);
    for (int i = 1; i <= 14; i++) queue_word(scl_pkg::MODE_READ, i);
    queue_word(scl_pkg::MODE_READ, 32'd100);
    queue_word(scl_pkg::MODE_READ, 32'd101);
    queue_word(scl_pkg::MODE_READ, 32'd102);
    queue_word(scl_pkg::MODE_WRITE, 32'd5);
    queue_word(scl_pkg::MODE_FLUSH, 32'h0000_0000);

    start_phase(32'hFFFF_FFFF, 0, 0);
    fill_random(27);
    start_phase($urandom, 56, 0);
    fill_random(27);
    start_phase(32'h8000_0000, 0, 56);
    fill_random(27);
    start_phase(32'h0000_0000, 12, 12);
    fill_random(27);

    // long receiver hold-off while the sender keeps offering
    start_phase($urandom, 0, 0);
    fill_random(27);
    hold_req = 1'b1;

    wait_drained();
    repeat (16) @(posedge clk);
    if (expected_lookups.size() != 0) begin
      $error("%0d expected result words never arrived", expected_lookups.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/scl_pkg.sv
rtl/scl_ctrl.sv
rtl/scl_dp.sv
rtl/sector_cache_lru_writeback_core.sv
bench/sector_cache_lru_writeback_core_tb.sv
